/* rtl/wstfd_pkg.sv */
// Shared types and constants for the WebSocket text frame deframer.
package wstfd_pkg;

  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_LEN   = 3'd1,
    PH_MASK  = 3'd2,
    PH_DATA  = 3'd3,
    PH_SKIP  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  localparam logic [7:0] FIN_MASK    = 8'h80;
  localparam logic [7:0] OPCODE_MASK = 8'h0F;
  localparam logic [7:0] OPCODE_TEXT = 8'h01;
  localparam logic [7:0] LEN_MASK    = 8'h7F;

  localparam int QDEPTH   = 4;
  localparam int QADDR_W  = $clog2(QDEPTH);
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  key;
    logic        last;
    logic [6:0]  length;
  } cmd_t;

endpackage

/* rtl/wstfd_front.sv */
// Header parser that classifies each received byte and issues output commands.
module wstfd_front #(
  parameter int MAX_SHORT_LENGTH = 125
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_accept,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              cmd_push,
  output wstfd_pkg::cmd_t   cmd
);

  localparam logic [6:0] LenMax = 7'(MAX_SHORT_LENGTH);

  wstfd_pkg::phase_t phase, phase_next;
  logic [7:0] key_bytes [4];
  logic [6:0] declared_length, declared_length_next;
  logic [6:0] payload_index, payload_index_next;
  logic [1:0] header_index, header_index_next;
  logic       key_write;
  logic [6:0] len_field;
  logic       fin;

  assign len_field = in_byte[6:0] & wstfd_pkg::LEN_MASK[6:0];
  assign fin = ({1'b0, payload_index} + 8'd1) >= {1'b0, declared_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= wstfd_pkg::PH_FIRST;
      declared_length <= '0;
      payload_index   <= '0;
      header_index    <= '0;
    end else begin
      phase           <= phase_next;
      declared_length <= declared_length_next;
      payload_index   <= payload_index_next;
      header_index    <= header_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (key_write) begin
      key_bytes[header_index] <= in_byte;
    end
  end

  always_comb begin
    wstfd_pkg::phase_t next;
    next                 = phase;
    phase_next           = phase;
    declared_length_next = declared_length;
    payload_index_next   = payload_index;
    header_index_next    = header_index;
    key_write            = 1'b0;
    cmd_push             = 1'b0;
    cmd.kind             = wstfd_pkg::KIND_REJECT;
    cmd.data             = '0;
    cmd.key              = '0;
    cmd.last             = 1'b1;
    cmd.length           = '0;
    if (in_valid && in_accept) begin
      case (phase)
        wstfd_pkg::PH_LEN: begin
          if (len_field > LenMax || in_last) begin
            cmd_push = 1'b1;
            next     = wstfd_pkg::PH_SKIP;
          end else begin
            declared_length_next = len_field;
            header_index_next    = '0;
            next                 = wstfd_pkg::PH_MASK;
          end
        end
        wstfd_pkg::PH_MASK: begin
          key_write = 1'b1;
          if (header_index == 2'd3) begin
            payload_index_next = '0;
            if (declared_length == '0) begin
              cmd_push = 1'b1;
              cmd.kind = wstfd_pkg::KIND_DONE;
              next     = wstfd_pkg::PH_SKIP;
            end else if (in_last) begin
              cmd_push = 1'b1;
              next     = wstfd_pkg::PH_SKIP;
            end else begin
              next = wstfd_pkg::PH_DATA;
            end
          end else if (in_last) begin
            cmd_push = 1'b1;
            next     = wstfd_pkg::PH_SKIP;
          end else begin
            header_index_next = header_index + 2'd1;
            next              = wstfd_pkg::PH_MASK;
          end
        end
        wstfd_pkg::PH_DATA: begin
          cmd_push = 1'b1;
          if (in_last && !fin) begin
            next = wstfd_pkg::PH_SKIP;
          end else begin
            cmd.kind           = wstfd_pkg::KIND_DATA;
            cmd.data           = in_byte;
            cmd.key            = key_bytes[payload_index[1:0]];
            cmd.last           = fin;
            cmd.length         = declared_length;
            payload_index_next = payload_index + 7'd1;
            next               = fin ? wstfd_pkg::PH_SKIP : wstfd_pkg::PH_DATA;
          end
        end
        wstfd_pkg::PH_SKIP: begin
          next = wstfd_pkg::PH_SKIP;
        end
        default: begin
          if ((in_byte & wstfd_pkg::FIN_MASK) == wstfd_pkg::FIN_MASK &&
              (in_byte & wstfd_pkg::OPCODE_MASK) == wstfd_pkg::OPCODE_TEXT &&
              !in_last) begin
            next = wstfd_pkg::PH_LEN;
          end else begin
            cmd_push = 1'b1;
            next     = wstfd_pkg::PH_SKIP;
          end
        end
      endcase
      phase_next = in_last ? wstfd_pkg::PH_FIRST : next;
    end
  end

endmodule

/* rtl/wstfd_queue.sv */
// Short command queue between the header parser and the output stage.
module wstfd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wstfd_pkg::cmd_t   push_cmd,
  input  logic              pop,
  output wstfd_pkg::cmd_t   head,
  output logic              empty,
  output logic              full
);

  wstfd_pkg::cmd_t entries [wstfd_pkg::QDEPTH];
  logic [wstfd_pkg::QADDR_W-1:0]  wr_ptr;
  logic [wstfd_pkg::QADDR_W-1:0]  rd_ptr;
  logic [wstfd_pkg::QCOUNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign empty   = (count == '0);
  assign full    = (count == wstfd_pkg::QCOUNT_W'(wstfd_pkg::QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* rtl/wstfd_back.sv */
// Output stage that unmasks payload bytes and holds each result beat.
module wstfd_back (
  input  logic              clk,
  input  logic              rst,
  input  wstfd_pkg::cmd_t   head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_byte,
  output logic              out_end,
  output logic [6:0]        out_length
);

  logic load;

  assign load = !empty && (!out_valid || out_ready);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind   <= head.kind;
      out_byte   <= head.data ^ head.key;
      out_end    <= head.last;
      out_length <= head.length;
    end
  end

endmodule

/* rtl/websocket_text_frame_deframer_core.sv */
// Top level of the WebSocket text frame deframer.
// The block takes one beat per cycle on the slave side and checks the text
// frame header, stores the four mask bytes and returns each payload byte
// unmasked; an empty frame gives one completion beat and a bad header or a
// chunk that ends early gives one rejection beat. A result passes through a
// four-entry command queue and an output register, and the input keeps flowing
// at one beat per cycle until that queue fills while the master side stalls.
module websocket_text_frame_deframer_core #(
  parameter int MAX_SHORT_LENGTH = 125
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] in_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [7:0] out_byte, [14:8] out_length, [15] zero
  output logic        m_tlast,
  output logic [1:0]  m_tuser   // [1:0] out_kind
);

  wstfd_pkg::cmd_t cmd;
  wstfd_pkg::cmd_t head;
  logic cmd_push;
  logic q_empty;
  logic q_full;
  logic q_pop;
  logic [7:0] out_byte;
  logic [6:0] out_length;

  assign s_tready = !q_full;

  wstfd_front #(
    .MAX_SHORT_LENGTH(MAX_SHORT_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_accept (s_tready),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .cmd_push  (cmd_push),
    .cmd       (cmd)
  );

  wstfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  wstfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_byte   (out_byte),
    .out_end    (m_tlast),
    .out_length (out_length)
  );

  assign m_tdata = {1'b0, out_length, out_byte};

endmodule

/* tb/tb.sv */
// Self-checking testbench for the WebSocket text frame deframer core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FRAME_MAX_LEN = 125;
  localparam int          RANDOM_ITEMS  = 1300;
  localparam int          DRAIN_CYCLES  = 20;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          HOLD_AFTER    = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic       chunk_end;
  } rx_byte_t;

  typedef struct packed {
    wstfd_pkg::kind_t kind;
    logic [7:0]       data;
    logic             frame_end;
    logic [6:0]       length;
  } frame_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  websocket_text_frame_deframer_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  rx_byte_t      chunk_q[$];
  frame_result_t unmasked_q[$];

  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned n_errors;
  int unsigned n_cycles;
  bit          in_taken;
  bit          out_taken;
  int unsigned tx_gap;
  int unsigned tx_calm;
  int unsigned rx_gap;
  int unsigned rx_calm;
  int unsigned hold_left;
  bit          hold_done;

  wstfd_pkg::phase_t ph = wstfd_pkg::PH_FIRST;
  logic [7:0] key_bytes [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
  logic [6:0] decl_len = 7'd0;
  logic [6:0] pay_idx = 7'd0;
  logic [1:0] hdr_idx = 2'd0;

  task automatic report(input string what);
    n_errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Tracks the frame state for one accepted byte and queues the unmasked
  // beat, completion or rejection that the byte produces.
  task automatic unmask_step(input logic [7:0] b, input logic chunk_end);
    wstfd_pkg::phase_t nxt;
    bit                give;
    bit                fin;
    frame_result_t     r;
    nxt  = wstfd_pkg::PH_SKIP;
    give = 1'b0;
    r    = '{kind: wstfd_pkg::KIND_REJECT, data: 8'h00, frame_end: 1'b1, length: 7'd0};
    case (ph)
      wstfd_pkg::PH_LEN: begin
        if (int'(b & wstfd_pkg::LEN_MASK) > FRAME_MAX_LEN || chunk_end) begin
          give = 1'b1;
        end else begin
          decl_len = b[6:0];
          hdr_idx  = 2'd0;
          nxt      = wstfd_pkg::PH_MASK;
        end
      end
      wstfd_pkg::PH_MASK: begin
        key_bytes[hdr_idx] = b;
        if (hdr_idx == 2'd3) begin
          pay_idx = 7'd0;
          if (decl_len == 7'd0) begin
            give   = 1'b1;
            r.kind = wstfd_pkg::KIND_DONE;
          end else if (chunk_end) begin
            give = 1'b1;
          end else begin
            nxt = wstfd_pkg::PH_DATA;
          end
        end else if (chunk_end) begin
          give = 1'b1;
        end else begin
          hdr_idx = hdr_idx + 2'd1;
          nxt     = wstfd_pkg::PH_MASK;
        end
      end
      wstfd_pkg::PH_DATA: begin
        fin  = (int'(pay_idx) + 1 >= int'(decl_len));
        give = 1'b1;
        if (!(chunk_end && !fin)) begin
          r = '{kind: wstfd_pkg::KIND_DATA, data: b ^ key_bytes[pay_idx[1:0]],
                frame_end: fin, length: decl_len};
          pay_idx = pay_idx + 7'd1;
          nxt     = fin ? wstfd_pkg::PH_SKIP : wstfd_pkg::PH_DATA;
        end
      end
      wstfd_pkg::PH_SKIP: nxt = wstfd_pkg::PH_SKIP;
      default: begin
        if ((b & wstfd_pkg::FIN_MASK) == wstfd_pkg::FIN_MASK &&
            (b & wstfd_pkg::OPCODE_MASK) == wstfd_pkg::OPCODE_TEXT && !chunk_end) begin
          nxt = wstfd_pkg::PH_LEN;
        end else begin
          give = 1'b1;
        end
      end
    endcase
    if (give) begin
      unmasked_q.push_back(r);
    end
    ph = chunk_end ? wstfd_pkg::PH_FIRST : nxt;
  endtask

  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic chunk_end);
    chunk_q.push_back('{data: b, chunk_end: chunk_end});
    n_queued++;
  endtask

  // Queues a chunk of total bytes: the first header byte, the length byte,
  // then random mask, payload and trailing bytes, with the end flag on the
  // final one.
  task automatic queue_chunk(input logic [7:0] first, input logic [7:0] len_byte,
                             input int unsigned total);
    push_byte(first, total == 1);
    if (total >= 2) begin
      push_byte(len_byte, total == 2);
    end
    for (int unsigned i = 2; i < total; i++) begin
      push_byte(8'($urandom), i == total - 1);
    end
  endtask

  task automatic queue_random_chunk();
    int unsigned len;
    int unsigned full;
    int unsigned total;
    logic [7:0]  first;
    logic [7:0]  len_byte;
    if ($urandom_range(0, 99) < 80) begin
      len = $urandom_range(0, 99);
      if (len < 5) begin
        len = FRAME_MAX_LEN;
      end else if (len < 12) begin
        len = $urandom_range(13, FRAME_MAX_LEN - 1);
      end else begin
        len = $urandom_range(0, 12);
      end
      first    = {1'b1, 3'($urandom), 4'h1};
      len_byte = {1'($urandom), 7'(len)};
      full     = 6 + len;
      if ($urandom_range(0, 99) < 12) begin
        total = $urandom_range(1, full - 1);
      end else if ($urandom_range(0, 99) < 70) begin
        total = full;
      end else begin
        total = full + $urandom_range(1, 4);
      end
    end else begin
      first    = $urandom_range(0, 1) ? 8'($urandom) : {1'b1, 3'($urandom), 4'h1};
      len_byte = 8'($urandom);
      total    = $urandom_range(1, 12);
    end
    queue_chunk(first, len_byte, total);
  endtask

  task automatic wait_idle();
    while (!(n_accepted == n_queued && unmasked_q.size() == 0)) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("websocket_text_frame_deframer_core regression: fail");
      $finish;
    end else if (!rst) begin
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        n_accepted++;
        unmask_step(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        out_taken = 1'b1;
        n_results++;
        if (unmasked_q.size() == 0) begin
          report($sformatf("unexpected beat kind %0d data %02h", m_tuser, m_tdata));
        end else begin
          want = unmasked_q.pop_front();
          if (m_tuser !== want.kind)
            report($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
          if (m_tdata[7:0] !== want.data)
            report($sformatf("byte %02h, expected %02h", m_tdata[7:0], want.data));
          if (m_tdata[14:8] !== want.length)
            report($sformatf("length %0d, expected %0d", m_tdata[14:8], want.length));
          if (m_tdata[15] !== 1'b0)
            report("padding bit of tdata is set");
          if (m_tlast !== want.frame_end)
            report($sformatf("end flag %0b, expected %0b", m_tlast, want.frame_end));
        end
      end
    end
  end

  always @(negedge clk) begin
    rx_byte_t nxt_byte;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !in_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (chunk_q.size() > 0) begin
        nxt_byte = chunk_q.pop_front();
        s_tdata  <= nxt_byte.data;
        s_tlast  <= nxt_byte.chunk_end;
        s_tvalid <= 1'b1;
        tx_gap   = pick_gap(tx_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // The receiver holds off once for a long stretch so that the block fills
  // up and stalls its input.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && n_results >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (out_taken) begin
        rx_gap = pick_gap(rx_calm);
      end
    end
  end

  initial begin
    int unsigned half;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_chunk(8'h01, 8'h00, 1);
    queue_chunk(8'h82, 8'h00, 2);
    queue_chunk(8'h81, 8'h00, 1);
    queue_chunk(8'hFF, 8'hFF, 3);
    queue_chunk(8'h81, 8'h05, 2);
    queue_chunk(8'h81, 8'h80, 6);
    queue_chunk(8'h81, 8'h03, 4);
    queue_chunk(8'h81, 8'h82, 7);
    queue_chunk(8'hF1, 8'h01, 9);
    queue_chunk(8'h81, 8'h7E, 3);
    queue_chunk(8'h81, 8'hFF, 8);
    wait_idle();

    half = n_queued + RANDOM_ITEMS / 2;
    while (n_queued < half) queue_random_chunk();
    wait_idle();
    while (n_queued < half + RANDOM_ITEMS / 2) queue_random_chunk();
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    while (unmasked_q.size() > 0) begin
      void'(unmasked_q.pop_front());
      report("expected beat never arrived");
    end
    if (n_errors == 0) begin
      $display("websocket_text_frame_deframer_core regression: pass");
    end else begin
      $display("websocket_text_frame_deframer_core regression: fail");
    end
    $finish;
  end

endmodule

/* websocket_text_frame_deframer_core.f */
rtl/wstfd_pkg.sv
rtl/wstfd_front.sv
rtl/wstfd_queue.sv
rtl/wstfd_back.sv
rtl/websocket_text_frame_deframer_core.sv
tb/tb.sv
